FILE: rtl/wbcbc_pkg.sv
// Shared types and constants for the white-box CBC block decryptor.
// No dependencies.
package wbcbc_pkg;

    localparam int RoundCount   = 17;
    localparam int LookupDepth  = 4096;
    localparam int LookupBits   = 12;

    localparam int InitWords    = 4096;
    localparam int LookupWords  = RoundCount * LookupDepth;
    localparam int MaskWords    = RoundCount * 256;
    localparam int XorWords     = RoundCount * 16;
    localparam int KeyWords     = RoundCount * 2;
    localparam int EndTabWords  = 4096;
    localparam int EndMaskWords = 128;
    localparam int EndXorWords  = 16;

    localparam int InitAw    = $clog2(InitWords);
    localparam int LookupAw  = $clog2(LookupWords);
    localparam int MaskAw    = $clog2(MaskWords);
    localparam int XorAw     = $clog2(XorWords);
    localparam int KeyAw     = $clog2(KeyWords);
    localparam int EndTabAw  = $clog2(EndTabWords);
    localparam int EndMaskAw = $clog2(EndMaskWords);
    localparam int EndXorAw  = $clog2(EndXorWords);

    localparam logic [63:0] Ones       = 64'h0101010101010101;
    localparam logic [63:0] Twos       = 64'h0202020202020202;
    localparam logic [7:0]  MixedLanes = 8'hC6;

    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_DECRYPT = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_INIT     = 3'd0,
        REG_LOOKUP   = 3'd1,
        REG_MASKS    = 3'd2,
        REG_XOR      = 3'd3,
        REG_KEYS     = 3'd4,
        REG_END_TAB  = 3'd5,
        REG_END_MASK = 3'd6,
        REG_END_XOR  = 3'd7
    } region_t;

    localparam logic CFG_IV_LOW  = 1'b0;
    localparam logic CFG_IV_HIGH = 1'b1;

    // Table write request from the top level to the store bank.
    typedef struct packed {
        logic        en;
        logic [2:0]  region;
        logic [16:0] slot;
        logic [63:0] data;
    } tbl_wr_t;

    // Read addresses issued by the sequencer.
    typedef struct packed {
        logic [InitAw-1:0]    init_a;
        logic [LookupAw-1:0]  lookup_a;
        logic [MaskAw-1:0]    mask_a;
        logic [XorAw-1:0]     xor_a;
        logic [KeyAw-1:0]     key_a;
        logic [EndTabAw-1:0]  end_tab_a;
        logic [EndMaskAw-1:0] end_mask_a;
        logic [EndXorAw-1:0]  end_xor_a;
    } tbl_rd_t;

    // Registered read data returned to the sequencer.
    typedef struct packed {
        logic [63:0] init_q;
        logic [63:0] lookup_q;
        logic [63:0] mask_q;
        logic [11:0] xor_q;
        logic [63:0] key_q;
        logic [7:0]  end_tab_q;
        logic [63:0] end_mask_q;
        logic [7:0]  end_xor_q;
    } tbl_q_t;

    // Lane byte i of w, as used by the mask step: byte i from the top, byte (7-i) from the bottom.
    function automatic logic [7:0] lane_byte(input logic [63:0] w, input logic [2:0] i);
        logic [5:0] sh;
        sh = {~i, 3'b000};
        return 8'(w >> sh);
    endfunction

    function automatic logic [7:0] parity_byte(input logic [63:0] v);
        logic [7:0] p;
        for (int k = 0; k < 8; k++)
            p[k] = ^v[8*k +: 8];
        return p;
    endfunction

    // Upper index bits: parity of byte k goes to bit 8+k, for bytes 0 to 3.
    function automatic logic [3:0] up_bits(input logic [63:0] v);
        logic [63:0] u;
        u = v ^ (v << 1);
        u = u ^ (u >> 2);
        u = u ^ (u >> 4);
        u = u & Twos;
        u = u | (u << 7);
        u = u | (u >> 14);
        return u[11:8];
    endfunction

endpackage

FILE: rtl/wbcbc_if.sv
// Valid/ready channel interfaces for the decryptor.
// Depends on nothing.
interface wbcbc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [2:0]  region;
    logic [16:0] slot;
    logic [63:0] table_word;
    logic [63:0] cipher_low;
    logic [63:0] cipher_high;
    modport source (output valid, action, region, slot, table_word, cipher_low, cipher_high,
                    input ready);
    modport sink (input valid, action, region, slot, table_word, cipher_low, cipher_high,
                  output ready);
endinterface

interface wbcbc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] plain_low;
    logic [63:0] plain_high;
    modport source (output valid, plain_low, plain_high, input ready);
    modport sink (input valid, plain_low, plain_high, output ready);
endinterface

interface wbcbc_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/whitebox_table_cbc_decrypt.sv
// Top level of the white-box CBC block decryptor.
// Depends on wbcbc_pkg, the channel interfaces, wbcbc_tables and wbcbc_seq.
//
// One transaction on the input channel is a table write, a chain restart,
// a block decrypt or no operation. Writes and restarts give no result. A
// decrypt walks the table stores one word at a time through a single read
// port per store, each read an address state followed by a data state:
// 16 init reads, then per round 2 key reads and 16 lookups each preceded
// by 16 mask reads, then 16 end tables with 8 mask reads each. The result
// sits in an output register, XORed with the chain, until taken; new input
// is held off while a decrypt runs and while its result waits. Tables must
// be written before use and have no reset; the IV registers and the chain
// reset to zero.
module whitebox_table_cbc_decrypt (
    input  logic        clk,
    input  logic        rst_n,
    wbcbc_in_if.sink    in_ch,
    wbcbc_out_if.source out_ch,
    wbcbc_cfg_if.sink   cfg
);
    logic [63:0] iv_low_reg, iv_high_reg;
    logic [63:0] chain_reg [2];
    logic [63:0] cin_reg [2];
    logic        out_valid_reg;
    logic [63:0] out_low_reg, out_high_reg;

    wbcbc_pkg::tbl_wr_t wr;
    wbcbc_pkg::tbl_rd_t rd;
    wbcbc_pkg::tbl_q_t  q;

    logic        busy, done, start, acc;
    logic [63:0] res_low, res_high;

    // Hold new input while a decrypt runs or its result has not left.
    assign in_ch.ready = !busy && !out_valid_reg;
    assign acc   = in_ch.valid && in_ch.ready;
    assign start = acc && (wbcbc_pkg::action_t'(in_ch.action) == wbcbc_pkg::ACT_DECRYPT);
    assign cfg.ready = 1'b1;

    assign wr.en     = acc && (wbcbc_pkg::action_t'(in_ch.action) == wbcbc_pkg::ACT_WRITE);
    assign wr.region = in_ch.region;
    assign wr.slot   = in_ch.slot;
    assign wr.data   = in_ch.table_word;

    wbcbc_tables u_tables (.clk, .wr, .rd, .q);

    wbcbc_seq u_seq (
        .clk, .rst_n, .start, .c_low(in_ch.cipher_low), .c_high(in_ch.cipher_high),
        .busy, .done, .res_low, .res_high, .rd, .q);

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.plain_low  = out_low_reg;
    assign out_ch.plain_high = out_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_low_reg    <= '0;
            iv_high_reg   <= '0;
            chain_reg[0]  <= '0;
            chain_reg[1]  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                if (cfg.index == wbcbc_pkg::CFG_IV_LOW)
                    iv_low_reg <= cfg.data;
                else
                    iv_high_reg <= cfg.data;
            end
            if (acc && wbcbc_pkg::action_t'(in_ch.action) == wbcbc_pkg::ACT_RESTART)
            begin
                chain_reg[0] <= iv_low_reg;
                chain_reg[1] <= iv_high_reg;
            end
            // Capture the ciphertext now; it becomes the chain at completion.
            if (start)
            begin
                cin_reg[0] <= in_ch.cipher_low;
                cin_reg[1] <= in_ch.cipher_high;
            end
            if (out_ch.valid && out_ch.ready)
                out_valid_reg <= 1'b0;
            if (done && !out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                out_low_reg   <= res_low ^ chain_reg[0];
                out_high_reg  <= res_high ^ chain_reg[1];
                chain_reg[0]  <= cin_reg[0];
                chain_reg[1]  <= cin_reg[1];
            end
        end
    end
endmodule

FILE: rtl/wbcbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module wbcbc_ram #(
    parameter int Width = 64,
    parameter int Depth = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] wa,
    input  logic [Width-1:0]         wd,
    input  logic [$clog2(Depth)-1:0] ra,
    output logic [Width-1:0]         rq
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rq <= mem[ra];
    end
endmodule

FILE: rtl/wbcbc_tables.sv
// Bank of the eight table stores; decodes table writes by region and slot.
// Depends on wbcbc_pkg and wbcbc_ram.
module wbcbc_tables (
    input  logic              clk,
    input  wbcbc_pkg::tbl_wr_t wr,
    input  wbcbc_pkg::tbl_rd_t rd,
    output wbcbc_pkg::tbl_q_t  q
);
    logic [7:0] we;

    always_comb
    begin
        we = '0;
        if (wr.en)
        begin
            case (wbcbc_pkg::region_t'(wr.region))
                wbcbc_pkg::REG_INIT:     we[0] = 32'(wr.slot) < wbcbc_pkg::InitWords;
                wbcbc_pkg::REG_LOOKUP:   we[1] = 32'(wr.slot) < wbcbc_pkg::LookupWords;
                wbcbc_pkg::REG_MASKS:    we[2] = 32'(wr.slot) < wbcbc_pkg::MaskWords;
                wbcbc_pkg::REG_XOR:      we[3] = 32'(wr.slot) < wbcbc_pkg::XorWords;
                wbcbc_pkg::REG_KEYS:     we[4] = 32'(wr.slot) < wbcbc_pkg::KeyWords;
                wbcbc_pkg::REG_END_TAB:  we[5] = 32'(wr.slot) < wbcbc_pkg::EndTabWords;
                wbcbc_pkg::REG_END_MASK: we[6] = 32'(wr.slot) < wbcbc_pkg::EndMaskWords;
                wbcbc_pkg::REG_END_XOR:  we[7] = 32'(wr.slot) < wbcbc_pkg::EndXorWords;
                default:                 we = '0;
            endcase
        end
    end

    wbcbc_ram #(.Width(64), .Depth(wbcbc_pkg::InitWords)) u_init (
        .clk, .we(we[0]), .wa(wr.slot[wbcbc_pkg::InitAw-1:0]), .wd(wr.data),
        .ra(rd.init_a), .rq(q.init_q));
    wbcbc_ram #(.Width(64), .Depth(wbcbc_pkg::LookupWords)) u_lookup (
        .clk, .we(we[1]), .wa(wr.slot[wbcbc_pkg::LookupAw-1:0]), .wd(wr.data),
        .ra(rd.lookup_a), .rq(q.lookup_q));
    wbcbc_ram #(.Width(64), .Depth(wbcbc_pkg::MaskWords)) u_mask (
        .clk, .we(we[2]), .wa(wr.slot[wbcbc_pkg::MaskAw-1:0]), .wd(wr.data),
        .ra(rd.mask_a), .rq(q.mask_q));
    wbcbc_ram #(.Width(12), .Depth(wbcbc_pkg::XorWords)) u_xor (
        .clk, .we(we[3]), .wa(wr.slot[wbcbc_pkg::XorAw-1:0]), .wd(wr.data[11:0]),
        .ra(rd.xor_a), .rq(q.xor_q));
    wbcbc_ram #(.Width(64), .Depth(wbcbc_pkg::KeyWords)) u_key (
        .clk, .we(we[4]), .wa(wr.slot[wbcbc_pkg::KeyAw-1:0]), .wd(wr.data),
        .ra(rd.key_a), .rq(q.key_q));
    wbcbc_ram #(.Width(8), .Depth(wbcbc_pkg::EndTabWords)) u_end_tab (
        .clk, .we(we[5]), .wa(wr.slot[wbcbc_pkg::EndTabAw-1:0]), .wd(wr.data[7:0]),
        .ra(rd.end_tab_a), .rq(q.end_tab_q));
    wbcbc_ram #(.Width(64), .Depth(wbcbc_pkg::EndMaskWords)) u_end_mask (
        .clk, .we(we[6]), .wa(wr.slot[wbcbc_pkg::EndMaskAw-1:0]), .wd(wr.data),
        .ra(rd.end_mask_a), .rq(q.end_mask_q));
    wbcbc_ram #(.Width(8), .Depth(wbcbc_pkg::EndXorWords)) u_end_xor (
        .clk, .we(we[7]), .wa(wr.slot[wbcbc_pkg::EndXorAw-1:0]), .wd(wr.data[7:0]),
        .ra(rd.end_xor_a), .rq(q.end_xor_q));
endmodule

FILE: rtl/wbcbc_seq.sv
// Round sequencer: walks init, lookup and end rounds over the table stores.
// Depends on wbcbc_pkg.
module wbcbc_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [63:0]        c_low,
    input  logic [63:0]        c_high,
    output logic               busy,
    output logic               done,
    output logic [63:0]        res_low,
    output logic [63:0]        res_high,
    output wbcbc_pkg::tbl_rd_t rd,
    input  wbcbc_pkg::tbl_q_t  q
);
    // Phases: INIT reads 16 init words. Each round reads, per lookup, the index
    // xor with the first of 16 masks, then the lookup word; keys come first.
    // END reads per table: end xor with the first of 8 masks, the end table byte.
    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_INIT_W, S_KEY, S_KEY_W, S_BLK, S_MASK, S_MASK_W,
        S_LOOK, S_LOOK_W, S_END, S_EMASK, S_EMASK_W, S_ETAB, S_ETAB_W, S_DONE
    } state_t;

    state_t      state_reg;
    logic [63:0] w_reg [2];
    logic [63:0] nw_reg [2];
    logic [4:0]  round_reg;
    logic [3:0]  blk_reg;
    logic [3:0]  step_reg;
    logic [63:0] up_reg;
    logic [63:0] lo_reg;
    logic [11:0] xr_reg;
    logic [7:0]  idx8_reg;

    logic        mixed;
    logic        src;
    logic [63:0] lane_w;
    logic [7:0]  lane_b;
    logic [63:0] mask_term;
    logic [11:0] look_idx;
    logic [7:0]  init_b;
    logic [2:0]  sub;

    assign mixed = (round_reg >= 5'd2) && (32'(round_reg) + 1 < wbcbc_pkg::RoundCount);
    assign src = blk_reg[3] ^ (mixed & wbcbc_pkg::MixedLanes[blk_reg[2:0]]);
    assign sub = step_reg[2:0];
    assign lane_w = (state_reg == S_EMASK_W) ? w_reg[blk_reg[3]] : w_reg[src];
    assign lane_b = wbcbc_pkg::lane_byte(lane_w, sub);
    assign mask_term = (state_reg == S_EMASK_W) ? (q.end_mask_q & {8{lane_b}})
                                                 : (q.mask_q & {8{lane_b}});
    assign look_idx = {wbcbc_pkg::up_bits(up_reg), wbcbc_pkg::parity_byte(lo_reg)} ^ xr_reg;
    assign init_b = 8'(w_reg[step_reg[3]] >> {step_reg[2:0], 3'b000});

    always_comb
    begin
        rd = '0;
        rd.init_a     = {step_reg, init_b};
        rd.key_a      = wbcbc_pkg::KeyAw'({round_reg, 1'b0} + {5'd0, blk_reg[3]});
        rd.xor_a      = wbcbc_pkg::XorAw'({round_reg, blk_reg});
        rd.mask_a     = wbcbc_pkg::MaskAw'({round_reg, blk_reg, step_reg});
        rd.lookup_a   = wbcbc_pkg::LookupAw'(32'(round_reg) * wbcbc_pkg::LookupDepth
                                             + 32'(look_idx));
        rd.end_xor_a  = blk_reg;
        rd.end_mask_a = {blk_reg, sub};
        rd.end_tab_a  = {blk_reg, idx8_reg ^ wbcbc_pkg::parity_byte(lo_reg)};
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign res_low = w_reg[0];
    assign res_high = w_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            round_reg <= '0;
            blk_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        w_reg[0]  <= c_low;
                        w_reg[1]  <= c_high;
                        nw_reg[0] <= '0;
                        nw_reg[1] <= '0;
                        step_reg  <= '0;
                        state_reg <= S_INIT;
                    end
                end
                S_INIT:
                    state_reg <= S_INIT_W;
                S_INIT_W:
                begin
                    nw_reg[step_reg[3]] <= nw_reg[step_reg[3]] ^ q.init_q;
                    if (step_reg == 4'd15)
                    begin
                        w_reg[0]  <= nw_reg[0];
                        w_reg[1]  <= nw_reg[1] ^ q.init_q;
                        round_reg <= '0;
                        blk_reg   <= '0;
                        state_reg <= S_KEY;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= S_INIT;
                    end
                end
                S_KEY:
                    state_reg <= S_KEY_W;
                S_KEY_W:
                begin
                    nw_reg[blk_reg[3]] <= q.key_q;
                    state_reg <= S_BLK;
                end
                S_BLK:
                begin
                    up_reg    <= '0;
                    lo_reg    <= '0;
                    step_reg  <= '0;
                    state_reg <= S_MASK;
                end
                S_MASK:
                    state_reg <= S_MASK_W;
                S_MASK_W:
                begin
                    if (step_reg == 4'd0)
                        xr_reg <= q.xor_q;
                    if (step_reg[3])
                        lo_reg <= lo_reg ^ mask_term;
                    else
                        up_reg <= up_reg ^ mask_term;
                    if (step_reg == 4'd15)
                        state_reg <= S_LOOK;
                    else
                    begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= S_MASK;
                    end
                end
                S_LOOK:
                    state_reg <= S_LOOK_W;
                S_LOOK_W:
                begin
                    if (blk_reg == 4'd15)
                    begin
                        w_reg[0] <= nw_reg[0];
                        w_reg[1] <= nw_reg[1] ^ q.lookup_q;
                        blk_reg  <= '0;
                        if (32'(round_reg) + 1 == wbcbc_pkg::RoundCount)
                        begin
                            nw_reg[0] <= '0;
                            nw_reg[1] <= '0;
                            state_reg <= S_END;
                        end
                        else
                        begin
                            round_reg <= round_reg + 5'd1;
                            state_reg <= S_KEY;
                        end
                    end
                    else
                    begin
                        nw_reg[blk_reg[3]] <= nw_reg[blk_reg[3]] ^ q.lookup_q;
                        blk_reg <= blk_reg + 4'd1;
                        state_reg <= (blk_reg == 4'd7) ? S_KEY : S_BLK;
                    end
                end
                S_END:
                begin
                    lo_reg    <= '0;
                    step_reg  <= '0;
                    state_reg <= S_EMASK;
                end
                S_EMASK:
                    state_reg <= S_EMASK_W;
                S_EMASK_W:
                begin
                    if (step_reg == 4'd0)
                        idx8_reg <= q.end_xor_q;
                    lo_reg <= lo_reg ^ mask_term;
                    if (step_reg == 4'd7)
                        state_reg <= S_ETAB;
                    else
                    begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= S_EMASK;
                    end
                end
                S_ETAB:
                    state_reg <= S_ETAB_W;
                S_ETAB_W:
                begin
                    nw_reg[blk_reg[3]][8*blk_reg[2:0] +: 8] <= q.end_tab_q;
                    if (blk_reg == 4'd15)
                    begin
                        w_reg[0]  <= nw_reg[0];
                        w_reg[1]  <= {q.end_tab_q, nw_reg[1][55:0]};
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        blk_reg   <= blk_reg + 4'd1;
                        state_reg <= S_END;
                    end
                end
                S_DONE:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/wbcbc_checker.sv
// Port-level checks on the decryptor; bound into the top level.
// Depends on wbcbc_pkg and, for the bind, the top level and its channel interfaces.
module wbcbc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic [1:0] in_action,
    input logic out_valid,
    input logic out_ready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    a_dec_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_action == wbcbc_pkg::ACT_DECRYPT |=> !in_ready)
        else $error("accepted input during decrypt");
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_action == wbcbc_pkg::ACT_DECRYPT
        |=> !out_valid || $past(out_valid))
        else $error("result before work");
endmodule

bind whitebox_table_cbc_decrypt wbcbc_checker u_chk (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_action(in_ch.action), .out_valid(out_ch.valid), .out_ready(out_ch.ready));

FILE: dv/tb_top.sv
// Testbench for whitebox_table_cbc_decrypt: fills every table store, then runs directed
// and random table writes, chain restarts and block decrypts against a built-in predictor.
// Depends on wbcbc_pkg, the channel interfaces in rtl/wbcbc_if.sv and the RTL top level.
module tb_top;
    import wbcbc_pkg::*;

    localparam int          Rounds     = 17;
    localparam logic [7:0]  CrossLanes = 8'hC6;
    localparam int          DrainWait  = 40;
    localparam longint      CycleLimit = 40000000;

    logic clk;
    logic rst_n;

    wbcbc_in_if  in_ch ();
    wbcbc_out_if out_ch ();
    wbcbc_cfg_if cfg ();

    whitebox_table_cbc_decrypt dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    always #1 clk = ~clk;

    // Shadow copy of the table stores, the IV registers and the chain.
    logic [63:0] init_store  [InitWords];
    logic [63:0] lookup_store[LookupWords];
    logic [63:0] mask_store  [MaskWords];
    logic [11:0] ixor_store  [XorWords];
    logic [63:0] key_store   [KeyWords];
    logic [7:0]  etab_store  [EndTabWords];
    logic [63:0] emask_store [EndMaskWords];
    logic [7:0]  exor_store  [EndXorWords];
    logic [63:0] iv_lo, iv_hi, chain_lo, chain_hi;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
    } plain_t;

    plain_t plain_q[$];

    int     errors;
    longint cycles;
    bit     steady;     // no idling on either side while set
    bit     hold_go;    // ask the receiver for one long hold-off

    // One row of the directed part.
    typedef struct {
        action_t     act;
        region_t     reg_sel;
        logic [16:0] slot;
        logic [63:0] word;
        logic [63:0] c_lo;
        logic [63:0] c_hi;
    } row_t;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // XOR of eight masks, each ANDed with one lane byte replicated across the word.
    function automatic logic [63:0] fold_masks(input logic [63:0] w, input int unsigned base,
                                               input bit end_round);
        logic [63:0] acc;
        logic [63:0] m;
        acc = '0;
        for (int i = 0; i < 8; i++)
        begin
            m = end_round ? emask_store[base + i] : mask_store[base + i];
            acc ^= m & {8{w[8*(7-i) +: 8]}};
        end
        return acc;
    endfunction

    function automatic logic [7:0] byte_parity(input logic [63:0] v);
        logic [7:0] p;
        for (int k = 0; k < 8; k++)
            p[k] = ^v[8*k +: 8];
        return p;
    endfunction

    function automatic logic [63:0] round_word(input logic [63:0] w, input int unsigned r,
                                               input int unsigned blk);
        int unsigned base;
        logic [7:0]  lo_bits;
        logic [7:0]  hi_par;
        logic [11:0] idx;
        base    = (r * 16 + blk) * 16;
        lo_bits = byte_parity(fold_masks(w, base + 8, 1'b0));
        hi_par  = byte_parity(fold_masks(w, base, 1'b0));
        idx     = {hi_par[3:0], lo_bits} ^ ixor_store[r * 16 + blk];
        return lookup_store[r * LookupDepth + idx];
    endfunction

    // Decrypt one block, XOR with the chain, queue the plaintext, advance the chain.
    function automatic void decrypt_predict(input logic [63:0] c_lo, input logic [63:0] c_hi);
        logic [63:0] w[2];
        logic [63:0] nw[2];
        logic [63:0] acc;
        int unsigned src;
        int unsigned t;
        logic [7:0]  idx;
        plain_t      p;
        w[0] = c_lo;
        w[1] = c_hi;
        for (int h = 0; h < 2; h++)
        begin
            acc = '0;
            for (int b = 0; b < 8; b++)
                acc ^= init_store[(h * 8 + b) * 256 + w[h][8*b +: 8]];
            nw[h] = acc;
        end
        w = nw;
        for (int r = 0; r < Rounds; r++)
        begin
            for (int h = 0; h < 2; h++)
            begin
                acc = key_store[r * 2 + h];
                for (int b = 0; b < 8; b++)
                begin
                    src = h;
                    // middle rounds cross some lookups over to the other half
                    if (r >= 2 && r < Rounds - 1 && CrossLanes[b])
                        src = src ^ 1;
                    acc ^= round_word(w[src], r, h * 8 + b);
                end
                nw[h] = acc;
            end
            w = nw;
        end
        for (int h = 0; h < 2; h++)
        begin
            acc = '0;
            for (int b = 0; b < 8; b++)
            begin
                t   = h * 8 + b;
                idx = byte_parity(fold_masks(w[h], t * 8, 1'b1)) ^ exor_store[t];
                acc[8*b +: 8] = etab_store[t * 256 + idx];
            end
            nw[h] = acc;
        end
        p.lo = nw[0] ^ chain_lo;
        p.hi = nw[1] ^ chain_hi;
        plain_q.push_back(p);
        chain_lo = c_lo;
        chain_hi = c_hi;
    endfunction

    // Apply one accepted transaction to the shadow state.
    function automatic void apply_item(input action_t act, input region_t rs,
                                       input logic [16:0] slot, input logic [63:0] word,
                                       input logic [63:0] c_lo, input logic [63:0] c_hi);
        int unsigned s;
        s = slot;
        case (act)
            ACT_WRITE:
                case (rs)
                    REG_INIT:     if (s < InitWords)    init_store[s]   = word;
                    REG_LOOKUP:   if (s < LookupWords)  lookup_store[s] = word;
                    REG_MASKS:    if (s < MaskWords)    mask_store[s]   = word;
                    REG_XOR:      if (s < XorWords)     ixor_store[s]   = word[11:0];
                    REG_KEYS:     if (s < KeyWords)     key_store[s]    = word;
                    REG_END_TAB:  if (s < EndTabWords)  etab_store[s]   = word[7:0];
                    REG_END_MASK: if (s < EndMaskWords) emask_store[s]  = word;
                    default:      if (s < EndXorWords)  exor_store[s]   = word[7:0];
                endcase
            ACT_DECRYPT:
                decrypt_predict(c_lo, c_hi);
            ACT_RESTART:
            begin
                chain_lo = iv_lo;
                chain_hi = iv_hi;
            end
            default: ;
        endcase
    endfunction

    function automatic int unsigned region_words(input region_t rs);
        case (rs)
            REG_INIT:     return InitWords;
            REG_LOOKUP:   return LookupWords;
            REG_MASKS:    return MaskWords;
            REG_XOR:      return XorWords;
            REG_KEYS:     return KeyWords;
            REG_END_TAB:  return EndTabWords;
            REG_END_MASK: return EndMaskWords;
            default:      return EndXorWords;
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one transaction; hold it until taken, then update the shadow state.
    task automatic send_item(input action_t act, input region_t rs, input logic [16:0] slot,
                             input logic [63:0] word, input logic [63:0] c_lo,
                             input logic [63:0] c_hi);
        if (!steady && $urandom_range(99) < 22)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.region      <= rs;
        in_ch.slot        <= slot;
        in_ch.table_word  <= word;
        in_ch.cipher_low  <= c_lo;
        in_ch.cipher_high <= c_hi;
        do
            @(posedge clk);
        while (!in_ch.ready);
        apply_item(act, rs, slot, word, c_lo, c_hi);
    endtask

    // Pause the sender until every plaintext is back and the block has settled.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (plain_q.size() != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == CFG_IV_LOW)
            iv_lo = value;
        else
            iv_hi = value;
    endtask

    // Random transaction: mostly writes and decrypts, some restarts, a little noise.
    task automatic send_random();
        int unsigned pick;
        int unsigned lim;
        region_t     rs;
        logic [16:0] slot;
        pick = $urandom_range(99);
        rs   = region_t'($urandom_range(7));
        lim  = region_words(rs);
        slot = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(lim - 1));
        if (pick < 45)
            send_item(ACT_WRITE, rs, slot, rand64(), rand64(), rand64());
        else if (pick < 82)
            send_item(ACT_DECRYPT, rs, slot, rand64(), rand64(), rand64());
        else if (pick < 94)
            send_item(ACT_RESTART, rs, slot, rand64(), rand64(), rand64());
        else
            send_item(ACT_NONE, rs, slot, rand64(), rand64(), rand64());
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_go = 1'b0;
                out_ch.ready <= 1'b0;
                // long enough that a result lands and the input backs up
                repeat (30000) @(posedge clk);
            end
            out_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 22);
        end
    end

    // Check each plaintext transaction against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (plain_q.size() == 0)
            begin
                $display("%0t: unexpected plaintext lo=%h hi=%h", $time,
                         out_ch.plain_low, out_ch.plain_high);
                errors++;
            end
            else
            begin
                if (out_ch.plain_low !== plain_q[0].lo)
                begin
                    $display("%0t: plain_low expected %h actual %h", $time,
                             plain_q[0].lo, out_ch.plain_low);
                    errors++;
                end
                if (out_ch.plain_high !== plain_q[0].hi)
                begin
                    $display("%0t: plain_high expected %h actual %h", $time,
                             plain_q[0].hi, out_ch.plain_high);
                    errors++;
                end
                void'(plain_q.pop_front());
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("[whitebox_table_cbc_decrypt] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        row_t        rows[$];
        logic [63:0] phase_iv[4][2];
        region_t     rs;

        clk               = 1'b0;
        rst_n             = 1'b0;
        errors            = 0;
        cycles            = 0;
        steady            = 1'b0;
        hold_go           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_NONE;
        in_ch.region      = REG_INIT;
        in_ch.slot        = '0;
        in_ch.table_word  = '0;
        in_ch.cipher_low  = '0;
        in_ch.cipher_high = '0;
        cfg.valid         = 1'b0;
        cfg.index         = CFG_IV_LOW;
        cfg.data          = '0;
        iv_lo             = '0;
        iv_hi             = '0;
        chain_lo          = '0;
        chain_hi          = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_IV_LOW, {$urandom, $urandom});
        write_reg(CFG_IV_HIGH, {$urandom, $urandom});

        // Fill every store so that no decrypt ever reads an unwritten word.
        for (int r = 0; r < 8; r++)
        begin
            rs = region_t'(r);
            for (int unsigned s = 0; s < region_words(rs); s++)
                send_item(ACT_WRITE, rs, 17'(s), {$urandom, $urandom}, '0, '0);
        end

        // Directed part: chain from reset values, field extremes, ignored writes,
        // the unused action, and the last word of every store written with all ones, the masks with zero.
        rows = '{
            '{ACT_DECRYPT, REG_INIT,     17'd0,      64'h0, 64'h0, 64'h0},
            '{ACT_DECRYPT, REG_INIT,     17'd0,      64'h0, '1,    '1},
            '{ACT_RESTART, REG_INIT,     17'd0,      64'h0, 64'h0, 64'h0},
            '{ACT_DECRYPT, REG_END_XOR,  17'h1FFFF,  '1,    64'h5555_aaaa_0f0f_f0f0,
              64'h8000_0000_0000_0001},
            '{ACT_WRITE,   REG_INIT,     17'd4096,   '1,    64'h0, 64'h0},
            '{ACT_WRITE,   REG_LOOKUP,   17'd69632,  '1,    64'h0, 64'h0},
            '{ACT_WRITE,   REG_MASKS,    17'h1FFFF,  '1,    64'h0, 64'h0},
            '{ACT_WRITE,   REG_XOR,      17'd272,    '1,    64'h0, 64'h0},
            '{ACT_WRITE,   REG_KEYS,     17'd34,     '1,    64'h0, 64'h0},
            '{ACT_WRITE,   REG_END_TAB,  17'd4096,   '1,    64'h0, 64'h0},
            '{ACT_WRITE,   REG_END_MASK, 17'd128,    '1,    64'h0, 64'h0},
            '{ACT_WRITE,   REG_END_XOR,  17'd16,     '1,    64'h0, 64'h0},
            '{ACT_NONE,    REG_END_XOR,  17'h1FFFF,  '1,    '1,    '1},
            '{ACT_DECRYPT, REG_INIT,     17'd0,      64'h0, 64'h0, 64'h0},
            '{ACT_WRITE,   REG_LOOKUP,   17'd69631,  '1,    64'h0, 64'h0},
            '{ACT_WRITE,   REG_XOR,      17'd271,    '1,    64'h0, 64'h0},
            '{ACT_WRITE,   REG_END_TAB,  17'd4095,   '1,    64'h0, 64'h0},
            '{ACT_WRITE,   REG_END_XOR,  17'd15,     '1,    64'h0, 64'h0},
            '{ACT_WRITE,   REG_KEYS,     17'd33,     '1,    64'h0, 64'h0},
            '{ACT_WRITE,   REG_MASKS,    17'd4351,   64'h0, 64'h0, 64'h0},
            '{ACT_WRITE,   REG_END_MASK, 17'd127,    '1,    64'h0, 64'h0},
            '{ACT_WRITE,   REG_INIT,     17'd4095,   '1,    64'h0, 64'h0},
            '{ACT_DECRYPT, REG_INIT,     17'd0,      64'h0, '1,    64'h0},
            '{ACT_DECRYPT, REG_INIT,     17'd0,      64'h0, 64'h0, '1}
        };
        foreach (rows[i])
            send_item(rows[i].act, rows[i].reg_sel, rows[i].slot, rows[i].word,
                      rows[i].c_lo, rows[i].c_hi);

        // Random phases, each under its own IV; the block drains before every
        // register write.
        phase_iv[0] = '{'1, '1};
        phase_iv[1] = '{64'h0, 64'h0};
        phase_iv[2] = '{{$urandom, $urandom}, {$urandom, $urandom}};
        phase_iv[3] = '{64'h8000_0000_0000_0000, 64'h1};
        for (int p = 0; p < 4; p++)
        begin
            drain();
            write_reg(CFG_IV_LOW, phase_iv[p][0]);
            write_reg(CFG_IV_HIGH, phase_iv[p][1]);
            steady = (p == 1);
            send_item(ACT_RESTART, REG_INIT, '0, '0, '0, '0);
            for (int n = 0; n < 230; n++)
            begin
                if (p == 2 && n == 20)
                    hold_go = 1'b1;
                send_random();
            end
        end
        steady = 1'b0;

        drain();
        repeat (DrainWait) @(posedge clk);
        if (errors == 0)
            $display("[whitebox_table_cbc_decrypt] OK");
        else
            $display("[whitebox_table_cbc_decrypt] ERROR");
        $finish;
    end

endmodule

FILE: whitebox_table_cbc_decrypt.f
rtl/wbcbc_pkg.sv
rtl/wbcbc_if.sv
rtl/wbcbc_ram.sv
rtl/wbcbc_tables.sv
rtl/wbcbc_seq.sv
rtl/whitebox_table_cbc_decrypt.sv
rtl/wbcbc_checker.sv
dv/tb_top.sv
